// File: src/csdc_pkg.sv
// Shared types, codes and defaults for the clock set and dimming controller.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package csdc_pkg;

  // Default geometry of the clock face.
  localparam int HOURS_DEFAULT   = 12;
  localparam int MINUTES_DEFAULT = 24;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int LEVEL_W    = 8;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_SECONDS    = 2'd0;
  localparam logic [1:0] REG_LEVEL_MIN  = 2'd1;
  localparam logic [1:0] REG_LEVEL_MAX  = 2'd2;
  localparam logic [1:0] REG_LEVEL_STEP = 2'd3;

  // Register reset values.
  localparam logic [7:0] SECONDS_RESET    = 8'd150;
  localparam logic [7:0] LEVEL_MIN_RESET  = 8'd0;
  localparam logic [7:0] LEVEL_MAX_RESET  = 8'd255;
  localparam logic [7:0] LEVEL_STEP_RESET = 8'd16;

  // Request kinds.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_KEYS  = 2'd1;
  localparam logic [1:0] FUNC_LUMA  = 2'd2;
  localparam logic [1:0] FUNC_POWER = 2'd3;

  // Operating modes.
  localparam logic [1:0] MODE_REGULAR     = 2'd0;
  localparam logic [1:0] MODE_SET_HOURS   = 2'd1;
  localparam logic [1:0] MODE_SET_MINUTES = 2'd2;

  // Display effects.
  localparam logic [1:0] EFFECT_RISE   = 2'd0;
  localparam logic [1:0] EFFECT_BLINK  = 2'd1;
  localparam logic [1:0] EFFECT_STEADY = 2'd2;

  // Bit positions in the held-key vector.
  localparam int KEY_UP  = 0;
  localparam int KEY_DN  = 1;
  localparam int KEY_SEL = 2;

  typedef struct packed {
    logic [7:0] seconds_per_hyperminute;
    logic [7:0] level_min;
    logic [7:0] level_max;
    logic [7:0] level_step;
  } cfg_t;

  typedef struct packed {
    logic [1:0] func;
    logic       key_up;
    logic       key_dn;
    logic       key_sel;
    logic       its_dark;
    logic       supply_ok;
  } item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] hour_effect;
    logic [1:0] minute_effect;
    logic       hour_refresh;
    logic       minute_refresh;
  } res_ctl_t;

endpackage

`default_nettype wire

// File: src/csdc_cfg.sv
// Configuration register file with an APB-style access port.
// Depends on csdc_pkg for the register map, reset values and cfg_t.
`default_nettype none

module csdc_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [csdc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [csdc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [csdc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output csdc_pkg::cfg_t                      cfg
);
  import csdc_pkg::*;

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[CFG_ADDR_W-1:2];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seconds_per_hyperminute <= SECONDS_RESET;
      cfg.level_min               <= LEVEL_MIN_RESET;
      cfg.level_max               <= LEVEL_MAX_RESET;
      cfg.level_step              <= LEVEL_STEP_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_SECONDS:    cfg.seconds_per_hyperminute <= pwdata[7:0];
        REG_LEVEL_MIN:  cfg.level_min               <= pwdata[7:0];
        REG_LEVEL_MAX:  cfg.level_max               <= pwdata[7:0];
        REG_LEVEL_STEP: cfg.level_step              <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_SECONDS:    prdata = CFG_DATA_W'(cfg.seconds_per_hyperminute);
      REG_LEVEL_MIN:  prdata = CFG_DATA_W'(cfg.level_min);
      REG_LEVEL_MAX:  prdata = CFG_DATA_W'(cfg.level_max);
      REG_LEVEL_STEP: prdata = CFG_DATA_W'(cfg.level_step);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: src/csdc_level.sv
// Brightness stepper: an optional up step followed by an optional down step,
// each saturating at the configured limits. Depends on csdc_pkg for cfg_t.
`default_nettype none

module csdc_level (
  input  csdc_pkg::cfg_t                 cfg,
  input  logic [csdc_pkg::LEVEL_W-1:0]   level,
  input  logic                           step_up,
  input  logic                           step_down,
  output logic [csdc_pkg::LEVEL_W-1:0]   result
);
  import csdc_pkg::*;

  logic [LEVEL_W:0]   up_sum;
  logic [LEVEL_W-1:0] after_up;
  logic [LEVEL_W-1:0] room;

  // Up: add the step and clamp at the maximum, unless already at or above it.
  always_comb begin
    up_sum = {1'b0, level} + {1'b0, cfg.level_step};
    if (step_up && (level < cfg.level_max)) begin
      after_up = (up_sum > {1'b0, cfg.level_max}) ? cfg.level_max : up_sum[LEVEL_W-1:0];
    end else begin
      after_up = level;
    end
  end

  // Down: land on the minimum when the distance to it is no more than a step.
  always_comb begin
    room = after_up - cfg.level_min;
    if (step_down && (after_up > cfg.level_min)) begin
      result = (room <= cfg.level_step) ? cfg.level_min : after_up - cfg.level_step;
    end else begin
      result = after_up;
    end
  end

endmodule

`default_nettype wire

// File: src/csdc_core.sv
// Clock state and the next-state logic for one request: time keeping, key
// edges, mode cycling and brightness. Depends on csdc_pkg and csdc_level.
`default_nettype none

module csdc_core #(
  parameter int HOURS_PER_CYCLE  = csdc_pkg::HOURS_DEFAULT,
  parameter int MINUTES_PER_HOUR = csdc_pkg::MINUTES_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  fire,
  input  csdc_pkg::item_t                       item,
  input  csdc_pkg::cfg_t                        cfg,
  output logic [$clog2(HOURS_PER_CYCLE)-1:0]    hour_next,
  output logic [$clog2(MINUTES_PER_HOUR)-1:0]   minute_next,
  output logic [csdc_pkg::LEVEL_W-1:0]          level_next,
  output csdc_pkg::res_ctl_t                    ctl_next
);
  import csdc_pkg::*;

  localparam int HW = $clog2(HOURS_PER_CYCLE);
  localparam int MW = $clog2(MINUTES_PER_HOUR);

  logic [7:0]         second_count;
  logic [MW-1:0]      minute_index;
  logic [HW-1:0]      hour_index;
  logic [1:0]         mode_state;
  logic [2:0]         keys_held;
  logic [LEVEL_W-1:0] dark_level;
  logic [LEVEL_W-1:0] light_level;
  logic [LEVEL_W-1:0] level_in_use;

  logic [7:0]         second_count_next;
  logic [MW-1:0]      minute_index_next;
  logic [HW-1:0]      hour_index_next;
  logic [1:0]         mode_state_next;
  logic [2:0]         keys_held_next;
  logic [LEVEL_W-1:0] dark_level_next;
  logic [LEVEL_W-1:0] light_level_next;
  logic [LEVEL_W-1:0] level_in_use_next;

  logic               up_edge;
  logic               down_edge;
  logic               menu_edge;
  logic [8:0]         second_inc;
  logic [HW-1:0]      hour_set;
  logic [MW-1:0]      minute_set;
  logic [LEVEL_W-1:0] chosen_level;
  logic [LEVEL_W-1:0] stepped_level;
  logic               hr_ref;
  logic               mn_ref;

  function automatic logic [HW-1:0] hour_up(input logic [HW-1:0] h);
    return (({1'b0, h} + (HW+1)'(1)) >= (HW+1)'(HOURS_PER_CYCLE)) ? '0 : h + HW'(1);
  endfunction

  function automatic logic [HW-1:0] hour_down(input logic [HW-1:0] h);
    return (h == '0) ? HW'(HOURS_PER_CYCLE - 1) : h - HW'(1);
  endfunction

  function automatic logic [MW-1:0] minute_up(input logic [MW-1:0] m);
    return (({1'b0, m} + (MW+1)'(1)) >= (MW+1)'(MINUTES_PER_HOUR)) ? '0 : m + MW'(1);
  endfunction

  function automatic logic [MW-1:0] minute_down(input logic [MW-1:0] m);
    return (m == '0) ? MW'(MINUTES_PER_HOUR - 1) : m - MW'(1);
  endfunction

  // A key acts only on its press edge.
  assign up_edge   = item.key_up  && !keys_held[KEY_UP];
  assign down_edge = item.key_dn  && !keys_held[KEY_DN];
  assign menu_edge = item.key_sel && !keys_held[KEY_SEL];

  // Up is handled before down, so both may apply within one poll.
  always_comb begin
    hour_set   = up_edge ? hour_up(hour_index) : hour_index;
    hour_set   = down_edge ? hour_down(hour_set) : hour_set;
    minute_set = up_edge ? minute_up(minute_index) : minute_index;
    minute_set = down_edge ? minute_down(minute_set) : minute_set;
  end

  assign chosen_level = item.its_dark ? dark_level : light_level;
  assign second_inc   = {1'b0, second_count} + 9'd1;

  csdc_level u_level (
    .cfg       (cfg),
    .level     (chosen_level),
    .step_up   (up_edge),
    .step_down (down_edge),
    .result    (stepped_level)
  );

  always_comb begin
    second_count_next = second_count;
    minute_index_next = minute_index;
    hour_index_next   = hour_index;
    mode_state_next   = mode_state;
    keys_held_next    = keys_held;
    dark_level_next   = dark_level;
    light_level_next  = light_level;
    level_in_use_next = level_in_use;
    hr_ref            = 1'b0;
    mn_ref            = 1'b0;
    unique case (item.func)
      FUNC_TICK: begin
        if (mode_state == MODE_REGULAR) begin
          if (second_inc > {1'b0, cfg.seconds_per_hyperminute}) begin
            second_count_next = 8'd1;
            minute_index_next = minute_up(minute_index);
            mn_ref            = item.supply_ok;
            if (minute_index_next == '0) begin
              hour_index_next = hour_up(hour_index);
              hr_ref          = item.supply_ok;
            end
          end else begin
            second_count_next = second_inc[7:0];
          end
        end
      end
      FUNC_KEYS: begin
        // After a poll each held bit simply follows the key level.
        keys_held_next = {item.key_sel, item.key_dn, item.key_up};
        if (mode_state == MODE_SET_HOURS) begin
          hour_index_next = hour_set;
          hr_ref          = up_edge || down_edge;
        end else if (mode_state == MODE_SET_MINUTES) begin
          minute_index_next = minute_set;
          mn_ref            = up_edge || down_edge;
        end else if (up_edge || down_edge) begin
          level_in_use_next = stepped_level;
          if (item.its_dark) begin
            dark_level_next = stepped_level;
          end else begin
            light_level_next = stepped_level;
          end
        end
        if (menu_edge) begin
          mode_state_next = (mode_state >= MODE_SET_MINUTES) ? MODE_REGULAR
                                                             : mode_state + 2'd1;
          hr_ref = 1'b1;
          mn_ref = 1'b1;
        end
      end
      FUNC_LUMA: begin
        level_in_use_next = chosen_level;
      end
      FUNC_POWER: begin
        keys_held_next  = '0;
        mode_state_next = MODE_REGULAR;
        hr_ref          = 1'b1;
        mn_ref          = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second_count <= 8'd1;
      minute_index <= '0;
      hour_index   <= HW'(1);
      mode_state   <= MODE_REGULAR;
      keys_held    <= '0;
      dark_level   <= LEVEL_MAX_RESET;
      light_level  <= LEVEL_MAX_RESET;
      level_in_use <= LEVEL_MAX_RESET;
    end else if (fire) begin
      second_count <= second_count_next;
      minute_index <= minute_index_next;
      hour_index   <= hour_index_next;
      mode_state   <= mode_state_next;
      keys_held    <= keys_held_next;
      dark_level   <= dark_level_next;
      light_level  <= light_level_next;
      level_in_use <= level_in_use_next;
    end
  end

  // Result fields reflect the state after this request.
  assign hour_next   = hour_index_next;
  assign minute_next = minute_index_next;
  assign level_next  = level_in_use_next;

  always_comb begin
    ctl_next.mode           = mode_state_next;
    ctl_next.hour_refresh   = hr_ref;
    ctl_next.minute_refresh = mn_ref;
    unique case (mode_state_next)
      MODE_REGULAR: begin
        ctl_next.hour_effect   = EFFECT_RISE;
        ctl_next.minute_effect = EFFECT_RISE;
      end
      MODE_SET_HOURS: begin
        ctl_next.hour_effect   = EFFECT_BLINK;
        ctl_next.minute_effect = EFFECT_STEADY;
      end
      MODE_SET_MINUTES: begin
        ctl_next.hour_effect   = EFFECT_STEADY;
        ctl_next.minute_effect = EFFECT_BLINK;
      end
      default: begin
        ctl_next.hour_effect   = EFFECT_STEADY;
        ctl_next.minute_effect = EFFECT_STEADY;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_hour_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, hour_index} < (HW+1)'(HOURS_PER_CYCLE))
    else $error("hour index out of range");

  a_minute_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, minute_index} < (MW+1)'(MINUTES_PER_HOUR))
    else $error("hyper-minute index out of range");

  a_power_restore: assert property (@(posedge clk) disable iff (rst)
    fire && (item.func == FUNC_POWER) |=> (keys_held == '0) && (mode_state == MODE_REGULAR))
    else $error("power restore did not release keys and return to regular mode");

  a_tick_frozen: assert property (@(posedge clk) disable iff (rst)
    fire && (item.func == FUNC_TICK) && (mode_state != MODE_REGULAR)
      |=> $stable(minute_index) && $stable(hour_index) && $stable(second_count))
    else $error("tick changed the time outside regular mode");
`endif

endmodule

`default_nettype wire

// File: src/clock_set_and_dimming_controller.sv
// Top level of the clock set and dimming controller: request and result
// registers with their handshakes. Depends on csdc_pkg, csdc_cfg, csdc_core.
//
//   port group      direction   handshake             payload
//   config (APB)    in/out      psel/penable/pready   paddr, pwdata, prdata
//   request         in          in_valid/in_stall     func, keys, its_dark, supply_ok
//   result          out         out_valid/out_stall   hour .. pwm_top
//
// Every request is held in the request register and yields one result in the
// result register; a new request can be taken every cycle while the result is
// not stalled, with a single pass through csdc_core between the two registers.
// Reset (rst, synchronous) empties both registers and restores the clock state
// and configuration defaults. When the result is stalled the request register
// still takes one more request; in_stall then rises until the result leaves.
`default_nettype none

module clock_set_and_dimming_controller #(
  parameter int HOURS_PER_CYCLE  = csdc_pkg::HOURS_DEFAULT,
  parameter int MINUTES_PER_HOUR = csdc_pkg::MINUTES_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration port.
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [csdc_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [csdc_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [csdc_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                  pready,
  // Request channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            func,
  input  logic                                  key_up,
  input  logic                                  key_dn,
  input  logic                                  key_sel,
  input  logic                                  its_dark,
  input  logic                                  supply_ok,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [$clog2(HOURS_PER_CYCLE)-1:0]    hour,
  output logic [$clog2(MINUTES_PER_HOUR)-1:0]   hyper_minute,
  output logic [1:0]                            mode,
  output logic [1:0]                            hour_effect,
  output logic [1:0]                            minute_effect,
  output logic                                  hour_refresh,
  output logic                                  minute_refresh,
  output logic [csdc_pkg::LEVEL_W-1:0]          pwm_top
);
  import csdc_pkg::*;

  localparam int HW = $clog2(HOURS_PER_CYCLE);
  localparam int MW = $clog2(MINUTES_PER_HOUR);

  cfg_t               cfg;
  item_t              s1_item;
  logic               s1_valid;
  logic               in_accept;
  logic               fire;
  logic [HW-1:0]      hour_res;
  logic [MW-1:0]      minute_res;
  logic [LEVEL_W-1:0] level_res;
  res_ctl_t           ctl_res;

  csdc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The held request moves on whenever the result register is empty or its
  // current result is being taken this cycle.
  assign fire      = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept || (s1_valid && !fire);
    end
  end

  // Request payload register; holds while stalled.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item.func      <= func;
      s1_item.key_up    <= key_up;
      s1_item.key_dn    <= key_dn;
      s1_item.key_sel   <= key_sel;
      s1_item.its_dark  <= its_dark;
      s1_item.supply_ok <= supply_ok;
    end
  end

  csdc_core #(
    .HOURS_PER_CYCLE  (HOURS_PER_CYCLE),
    .MINUTES_PER_HOUR (MINUTES_PER_HOUR)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (s1_item),
    .cfg         (cfg),
    .hour_next   (hour_res),
    .minute_next (minute_res),
    .level_next  (level_res),
    .ctl_next    (ctl_res)
  );

  // Result register: loaded on the same edge that commits the clock state.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fire || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      hour           <= hour_res;
      hyper_minute   <= minute_res;
      mode           <= ctl_res.mode;
      hour_effect    <= ctl_res.hour_effect;
      minute_effect  <= ctl_res.minute_effect;
      hour_refresh   <= ctl_res.hour_refresh;
      minute_refresh <= ctl_res.minute_refresh;
      pwm_top        <= level_res;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("request stalled with an empty request register");

  a_fire_fills_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("committed request produced no result");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |-> in_stall && !fire)
    else $error("request advanced while the result was stalled");
`endif

endmodule

`default_nettype wire
